// ===== hdl/amicable_pair_check_unit_defines.svh =====
// assertion macros shared by the amicable pair check unit
`ifndef AMICABLE_PAIR_CHECK_UNIT_DEFINES_SVH
`define AMICABLE_PAIR_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ACPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acpc assertion failed");

// next-cycle implication, checked outside reset
`define ACPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acpc assertion failed");

`endif

// ===== hdl/acpc_pkg.sv =====
// shared types and constants for the amicable pair check unit
package acpc_pkg;

   // width of each input value
   localparam int VALUE_WIDTH = 16;
   // width of the reported sums
   localparam int OUT_SUM_WIDTH = 18;
   // internal sum width: wide enough for the full aliquot sum and the output
   localparam int SUM_WIDTH = (VALUE_WIDTH + 3 > OUT_SUM_WIDTH) ?
                              VALUE_WIDTH + 3 : OUT_SUM_WIDTH;
   // bit index width for the shift-subtract remainder
   localparam int IDX_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_DIVIDE,
      LANE_CHECK
   } lane_state_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_RUN
   } ctrl_state_type;

   // what a lane reports to the controller and the merge stage
   typedef struct packed {
      logic                   busy;
      logic [VALUE_WIDTH-1:0] value;
      logic [SUM_WIDTH-1:0]   sum;
   } lane_status_type;

endpackage

// ===== hdl/acpc_lane.sv =====
// one trial-division lane: aliquot sum of a single value
`include "amicable_pair_check_unit_defines.svh"

module acpc_lane import acpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] value,
   output lane_status_type        status
);

   localparam logic [IDX_WIDTH-1:0] IDX_LAST = IDX_WIDTH'(VALUE_WIDTH - 1);

   lane_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] half_ff, half_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;

   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   // one shift-subtract step of the remainder
   always_comb begin
      trial = {rem_ff, value_ff[idx_ff]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LANE_IDLE: begin
            if (start) state_in = LANE_DIVIDE;
         end
         LANE_DIVIDE: begin
            if (idx_ff == '0) state_in = LANE_CHECK;
         end
         LANE_CHECK: begin
            if (divisor_ff >= half_ff) state_in = LANE_IDLE;
            else                       state_in = LANE_DIVIDE;
         end
         default: state_in = LANE_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      value_in   = value_ff;
      half_in    = half_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      unique case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               value_in   = value;
               half_in    = value >> 1;
               divisor_in = VALUE_WIDTH'(1);
               rem_in     = '0;
               idx_in     = IDX_LAST;
               sum_in     = '0;
            end
         end
         LANE_DIVIDE: begin
            rem_in = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            if (idx_ff != '0) idx_in = idx_ff - 1'b1;
         end
         LANE_CHECK: begin
            // candidates above half the value are never proper divisors of it
            if (rem_ff == '0 && divisor_ff <= half_ff)
               sum_in = sum_ff + SUM_WIDTH'(divisor_ff);
            divisor_in = divisor_ff + 1'b1;
            rem_in     = '0;
            idx_in     = IDX_LAST;
         end
         default: ;
      endcase
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= LANE_IDLE;
      else       state_ff <= state_in;
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      half_ff    <= half_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
   end

   // status out
   always_comb begin
      status.busy  = (state_ff != LANE_IDLE);
      status.value = value_ff;
      status.sum   = sum_ff;
   end

   `ACPC_ASSERT_IMPL(a_check_after_divide, clock, reset,
                     state_ff == LANE_CHECK, $past(state_ff) == LANE_DIVIDE)
   `ACPC_ASSERT_IMPL(a_divisor_nonzero, clock, reset,
                     state_ff == LANE_DIVIDE, divisor_ff != '0)

endmodule

// ===== hdl/acpc_merge.sv =====
// merge stage: cross-compares the lane sums and registers the result word
module acpc_merge import acpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     merge_valid,
   input  lane_status_type          lane_a,
   input  lane_status_type          lane_b,
   output logic                     rsp_valid,
   output logic                     rsp_are_amicable,
   output logic [OUT_SUM_WIDTH-1:0] rsp_first_divisor_sum,
   output logic [OUT_SUM_WIDTH-1:0] rsp_second_divisor_sum
);

   logic                     valid_ff, valid_in;
   logic                     amicable_ff, amicable_in;
   logic [OUT_SUM_WIDTH-1:0] sum_a_ff, sum_a_in;
   logic [OUT_SUM_WIDTH-1:0] sum_b_ff, sum_b_in;

   // full-width cross compare, truncated sums out
   always_comb begin
      valid_in    = merge_valid;
      amicable_in = (SUM_WIDTH'(lane_a.value) == lane_b.sum) &&
                    (SUM_WIDTH'(lane_b.value) == lane_a.sum);
      sum_a_in    = lane_a.sum[OUT_SUM_WIDTH-1:0];
      sum_b_in    = lane_b.sum[OUT_SUM_WIDTH-1:0];
   end

   // strobe register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // result word registers
   always_ff @(posedge clock) begin
      if (merge_valid) begin
         amicable_ff <= amicable_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_are_amicable       = amicable_ff;
   assign rsp_first_divisor_sum  = sum_a_ff;
   assign rsp_second_divisor_sum = sum_b_ff;

endmodule

// ===== hdl/amicable_pair_check_unit.sv =====
// each lane walks candidates 1..max(1, floor(v/2)) of its value v, 16 remainder steps plus one check per candidate
// throughput: one word at a time; start is taken again in the cycle the result shows
// results are strobed for one cycle on rsp_valid and cannot be held off
// synchronous active-high reset idles both lanes and drops busy and rsp_valid
`include "amicable_pair_check_unit_defines.svh"

module amicable_pair_check_unit import acpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [VALUE_WIDTH-1:0]   req_first_value,
   input  logic [VALUE_WIDTH-1:0]   req_second_value,
   output logic                     rsp_valid,
   output logic                     rsp_are_amicable,
   output logic [OUT_SUM_WIDTH-1:0] rsp_first_divisor_sum,
   output logic [OUT_SUM_WIDTH-1:0] rsp_second_divisor_sum
);

   ctrl_state_type  state_ff, state_in;
   logic            accept;
   logic            merge_valid;
   lane_status_type lane_a;
   lane_status_type lane_b;

   assign accept = start && !busy;

   // lanes, one per value of the pair
   acpc_lane u_lane_a (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .value  (req_first_value),
      .status (lane_a)
   );

   acpc_lane u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .value  (req_second_value),
      .status (lane_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (start) state_in = CTRL_RUN;
         end
         CTRL_RUN: begin
            if (!lane_a.busy && !lane_b.busy) state_in = CTRL_IDLE;
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      busy        = (state_ff != CTRL_IDLE);
      merge_valid = (state_ff == CTRL_RUN) && !lane_a.busy && !lane_b.busy;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CTRL_IDLE;
      else       state_ff <= state_in;
   end

   // merge and result register
   acpc_merge u_merge (
      .clock                  (clock),
      .reset                  (reset),
      .merge_valid            (merge_valid),
      .lane_a                 (lane_a),
      .lane_b                 (lane_b),
      .rsp_valid              (rsp_valid),
      .rsp_are_amicable       (rsp_are_amicable),
      .rsp_first_divisor_sum  (rsp_first_divisor_sum),
      .rsp_second_divisor_sum (rsp_second_divisor_sum)
   );

   `ACPC_ASSERT_NEXT(a_accept_sets_busy, clock, reset, accept, busy)
   `ACPC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ACPC_ASSERT_IMPL(a_lane_within_run, clock, reset,
                     lane_a.busy || lane_b.busy, state_ff == CTRL_RUN)

endmodule

// ===== bench/amicable_pair_check_unit_tb.sv =====
// self-checking testbench for the amicable pair check unit
`timescale 1ns / 100ps

module amicable_pair_check_unit_tb;
   import acpc_pkg::*;

   // run limit, well above the slowest correct run of this stimulus
   localparam longint unsigned CYCLE_LIMIT = 12_000_000;
   // quiet cycles after the last result word
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      logic                     amicable;
      logic [OUT_SUM_WIDTH-1:0] first_sum;
      logic [OUT_SUM_WIDTH-1:0] second_sum;
   } pair_verdict_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [VALUE_WIDTH-1:0]   req_first_value = '0;
   logic [VALUE_WIDTH-1:0]   req_second_value = '0;
   logic                     rsp_valid;
   logic                     rsp_are_amicable;
   logic [OUT_SUM_WIDTH-1:0] rsp_first_divisor_sum;
   logic [OUT_SUM_WIDTH-1:0] rsp_second_divisor_sum;

   pair_verdict_type pending_verdicts[$];
   pair_verdict_type oldest_verdict;
   int               error_count = 0;
   longint unsigned  cycle_count = 0;

   // known friendly pairs, each entry pairs with its neighbour
   logic [VALUE_WIDTH-1:0] friendly_values [10] =
      '{220, 284, 1184, 1210, 6, 6, 28, 28, 496, 496};

   amicable_pair_check_unit u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_first_value        (req_first_value),
      .req_second_value       (req_second_value),
      .rsp_valid              (rsp_valid),
      .rsp_are_amicable       (rsp_are_amicable),
      .rsp_first_divisor_sum  (rsp_first_divisor_sum),
      .rsp_second_divisor_sum (rsp_second_divisor_sum)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // sum of the divisors below v, by trial division up to its square root
   function automatic longint unsigned proper_divisor_total(longint unsigned v);
      longint unsigned total = 0;
      longint unsigned i;
      if (v == 0)
         return 0;
      for (i = 1; i * i <= v; i++) begin
         if (v % i == 0) begin
            total += i;
            if (v / i != i)
               total += v / i;
         end
      end
      return total - v;
   endfunction

   // expected result word for one pair; the flag uses the untruncated sums
   function automatic pair_verdict_type predict_verdict(logic [VALUE_WIDTH-1:0] a,
                                                        logic [VALUE_WIDTH-1:0] b);
      pair_verdict_type verdict;
      longint unsigned  sum_a = proper_divisor_total(a);
      longint unsigned  sum_b = proper_divisor_total(b);
      verdict.amicable   = (a == sum_b) && (b == sum_a);
      verdict.first_sum  = sum_a[OUT_SUM_WIDTH-1:0];
      verdict.second_sum = sum_b[OUT_SUM_WIDTH-1:0];
      return verdict;
   endfunction

   // sender gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 80);
   endfunction

   // offer one pair and hold it until the block takes it
   task automatic send_pair(input logic [VALUE_WIDTH-1:0] a, input logic [VALUE_WIDTH-1:0] b);
      start            <= 1'b1;
      req_first_value  <= a;
      req_second_value <= b;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_verdicts.push_back(predict_verdict(a, b));
   endtask

   // drop start for a number of cycles
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_with_gap(input logic [VALUE_WIDTH-1:0] a,
                                input logic [VALUE_WIDTH-1:0] b);
      send_pair(a, b);
      hold_off(pick_gap());
   endtask

   // stop sending until every outstanding word has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // widest values, one, and zero
   task automatic test_value_extremes();
      send_with_gap(16'hFFFF, 16'hFFFF);
      send_with_gap(1, 1);
      send_with_gap(0, 0);
      send_with_gap(0, 1);
      send_with_gap(1, 0);
   endtask

   // amicable pairs, the first two in both orders
   task automatic test_amicable_pairs();
      send_with_gap(220, 284);
      send_with_gap(284, 220);
      send_with_gap(1184, 1210);
      send_with_gap(1210, 1184);
      send_with_gap(2620, 2924);
   endtask

   // perfect numbers against themselves, and near misses
   task automatic test_perfect_values();
      send_with_gap(6, 6);
      send_with_gap(28, 28);
      send_with_gap(496, 496);
      send_with_gap(8128, 8128);
      send_with_gap(6, 28);
      send_with_gap(220, 220);
      send_with_gap(284, 284);
   endtask

   // squares, primes, abundant and power-of-two values
   task automatic test_divisor_shapes();
      send_with_gap(4, 9);
      send_with_gap(2, 3);
      send_with_gap(12, 16);
      send_with_gap(1024, 1023);
      send_with_gap(36, 49);
   endtask

   // a run of small pairs with no idle cycles between them
   task automatic test_back_to_back();
      repeat (8)
         send_pair(VALUE_WIDTH'($urandom_range(1, 63)), VALUE_WIDTH'($urandom_range(1, 63)));
      hold_off(1);
   endtask

   // random pairs, mostly small, some friendly, a few wider
   task automatic test_random_pairs();
      int                     roll;
      int                     k;
      logic [VALUE_WIDTH-1:0] a;
      logic [VALUE_WIDTH-1:0] b;
      for (int n = 0; n < 70; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            k = 2 * $urandom_range(0, 4);
            a = friendly_values[k];
            b = friendly_values[k + 1];
            if ($urandom_range(0, 1))
               {a, b} = {b, a};
         end else if (roll < 14) begin
            a = VALUE_WIDTH'($urandom_range(1, 600));
            b = a;
         end else if (roll < 80) begin
            a = VALUE_WIDTH'($urandom_range(1, 255));
            b = VALUE_WIDTH'($urandom_range(1, 255));
         end else if (roll < 97) begin
            a = VALUE_WIDTH'($urandom_range(1, 4095));
            b = VALUE_WIDTH'($urandom_range(1, 4095));
         end else begin
            a = VALUE_WIDTH'($urandom_range(1, 8191));
            b = VALUE_WIDTH'($urandom_range(1, 63));
         end
         send_with_gap(a, b);
         if (n % 30 == 29)
            wait_drained();
      end
   endtask

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            if (rsp_are_amicable !== oldest_verdict.amicable) begin
               $error("are_amicable: expected %0d, got %0d",
                      oldest_verdict.amicable, rsp_are_amicable);
               error_count++;
            end
            if (rsp_first_divisor_sum !== oldest_verdict.first_sum) begin
               $error("first_divisor_sum: expected %0d, got %0d",
                      oldest_verdict.first_sum, rsp_first_divisor_sum);
               error_count++;
            end
            if (rsp_second_divisor_sum !== oldest_verdict.second_sum) begin
               $error("second_divisor_sum: expected %0d, got %0d",
                      oldest_verdict.second_sum, rsp_second_divisor_sum);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_value_extremes();
      test_amicable_pairs();
      test_perfect_values();
      test_divisor_shapes();
      wait_drained();
      test_back_to_back();
      test_random_pairs();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
